/* rtl/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
`default_nettype none
package sfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;
    localparam int LEN_W       = 4;
    localparam int WORD_W      = 64;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PATTERN_LEN   = 2'd0,
        CFG_PATTERN_BYTES = 2'd1,
        CFG_REPLACE_LEN   = 2'd2,
        CFG_REPLACE_BYTES = 2'd3
    } cfg_reg_t;

    // One burst of output bytes, produced by the front end for an accepted input byte.
    typedef struct packed {
        logic [WORD_W-1:0] data;   // byte k in bits 8k+7..8k
        logic [IDX_W-1:0]  nm1;    // number of bytes minus one
        logic              last;   // final byte of the burst ends the text
    } sfr_entry_t;

endpackage
`default_nettype wire

/* rtl/sfr_front.sv */
// Front end: configuration registers, match window and burst classification.
`default_nettype none
module sfr_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [sfr_pkg::WORD_W-1:0]  cfg_wdata,
    input  wire logic                        in_valid,
    input  wire logic [sfr_pkg::BYTE_W-1:0]  in_byte,
    input  wire logic                        in_last,
    output logic                             in_ready,
    input  wire logic                        q_full,
    output logic                             q_push,
    output sfr_pkg::sfr_entry_t              q_entry
);
    import sfr_pkg::*;

    logic [LEN_W-1:0]   pattern_len_reg;
    logic [WORD_W-1:0]  pattern_bytes_reg;
    logic [LEN_W-1:0]   replace_len_reg;
    logic [WORD_W-1:0]  replace_bytes_reg;

    logic [BYTE_W-1:0]  window_reg [PATTERN_MAX];
    logic [BYTE_W-1:0]  window_next [PATTERN_MAX];
    logic [IDX_W-1:0]   count_reg;
    logic [IDX_W-1:0]   count_next;

    logic [BYTE_W-1:0]  pushed [PATTERN_MAX];
    logic [LEN_W-1:0]   plen;
    logic [LEN_W-1:0]   rlen;
    logic [LEN_W-1:0]   pushed_cnt;
    logic               accept;
    logic               match;
    logic               pop;
    logic [WORD_W-1:0]  pushed_word;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                   input logic [LEN_W-1:0] maxv);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign plen       = clamp_len(pattern_len_reg, LEN_W'(PATTERN_MAX));
    assign rlen       = clamp_len(replace_len_reg, LEN_W'(REPLACE_MAX));
    assign pushed_cnt = {1'b0, count_reg} + LEN_W'(1);

    always_comb begin
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pushed[k] = (IDX_W'(k) == count_reg) ? in_byte : window_reg[k];
            pushed_word[k*BYTE_W +: BYTE_W] = pushed[k];
        end
    end

    // Compare only the first plen bytes, and only when the window is exactly full.
    always_comb begin
        match = (pushed_cnt == plen);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            if ((LEN_W'(k) < plen) &&
                (pushed[k] != pattern_bytes_reg[k*BYTE_W +: BYTE_W])) begin
                match = 1'b0;
            end
        end
    end

    assign pop = (pushed_cnt >= plen) && !match;

    always_comb begin
        for (int k = 0; k < PATTERN_MAX - 1; k++) begin
            window_next[k] = pop ? pushed[k+1] : pushed[k];
        end
        window_next[PATTERN_MAX-1] = pushed[PATTERN_MAX-1];

        if (match || in_last) begin
            count_next = '0;
        end else if (pop) begin
            count_next = count_reg;
        end else begin
            count_next = pushed_cnt[IDX_W-1:0];
        end
    end

    always_comb begin
        q_entry.last = in_last;
        priority if (match) begin
            q_entry.data = replace_bytes_reg;
            q_entry.nm1  = IDX_W'(rlen - LEN_W'(1));
        end else if (in_last) begin
            q_entry.data = pushed_word;
            q_entry.nm1  = count_reg;
        end else begin
            q_entry.data = pushed_word;
            q_entry.nm1  = '0;
        end
        q_push = accept && (match || pop || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_len_reg   <= LEN_W'(1);
            pattern_bytes_reg <= '0;
            replace_len_reg   <= LEN_W'(1);
            replace_bytes_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PATTERN_LEN:   pattern_len_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_PATTERN_BYTES: pattern_bytes_reg <= cfg_wdata;
                CFG_REPLACE_LEN:   replace_len_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_REPLACE_BYTES: replace_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg <= window_next;
        end
    end

    // A match always empties the window.
    a_match_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && match |=> count_reg == '0)
        else $error("window not empty after a match");

endmodule
`default_nettype wire

/* rtl/sfr_queue.sv */
// Short queue of output bursts between the front end and the back end.
`default_nettype none
module sfr_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  sfr_pkg::sfr_entry_t       push_entry,
    input  wire logic                 pop,
    output sfr_pkg::sfr_entry_t       head,
    output logic                      not_empty,
    output logic                      full
);
    import sfr_pkg::*;

    sfr_entry_t          slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head      = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !not_empty |-> !pop)
        else $error("pop from an empty queue");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0])
        else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

/* rtl/sfr_back.sv */
// Back end: serialises queued bursts into the registered output stream.
`default_nettype none
module sfr_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  sfr_pkg::sfr_entry_t              head,
    input  wire logic                        q_not_empty,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [sfr_pkg::BYTE_W-1:0]       m_tdata,
    output logic                             m_tlast
);
    import sfr_pkg::*;

    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [BYTE_W-1:0]   m_tdata_reg;
    logic [BYTE_W-1:0]   m_tdata_next;
    logic                m_tlast_reg;
    logic                m_tlast_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                load;
    logic                end_of_burst;

    assign load         = !m_tvalid_reg || m_tready;
    assign end_of_burst = (idx_reg == head.nm1);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        idx_next      = idx_reg;
        q_pop         = 1'b0;
        if (load) begin
            m_tvalid_next = q_not_empty;
            if (q_not_empty) begin
                m_tdata_next = head.data[{idx_reg, 3'b000} +: BYTE_W];
                m_tlast_next = head.last && end_of_burst;
                if (end_of_burst) begin
                    idx_next = '0;
                    q_pop    = 1'b1;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A final byte is always the end of its burst.
    a_last_ends_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        load && q_not_empty && head.last && end_of_burst |=> idx_reg == '0)
        else $error("burst index not rewound after the final byte");

endmodule
`default_nettype wire

/* rtl/stream_find_replace_top.sv */
// Top level of the streaming find-and-replace block.
// The block rewrites a byte stream, replacing every non-overlapping occurrence of
// a configured pattern (one to eight bytes) with a replacement (one to eight bytes).
// Input transactions arrive on the s_ stream, one text byte each, with s_tlast
// on the final byte of the text. Results leave on the m_ stream, one byte per
// transaction, with m_tlast on the final byte of the rewritten text.
// The configuration port must be written only while the block is idle; the block
// itself does not enforce this, and the lengths are clamped to one to eight bytes.
// The front end holds up to seven pending bytes in its window and turns each
// accepted byte into a burst of zero to eight output bytes, which it places in
// a four-entry queue. The back end emits one byte per cycle from that queue
// while the receiver is ready. An output byte passes through the queue and
// the output register. Throughput is one input transaction per cycle; a
// replacement longer than one byte, or a flush at the end of the text, can make
// the queue fill, and the input is then held off while the queue is full.
// When the receiver stalls the output register holds its transaction and the
// queue keeps absorbing input until it is full.
// Reset empties the window and the queue and restores the configuration to
// single-byte pattern and replacement, both zero.
`default_nettype none
module stream_find_replace_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Configuration write port.
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [sfr_pkg::WORD_W-1:0]  cfg_wdata,
    // Input stream.
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // in_byte [7:0]
    input  wire logic                        s_tlast,
    // Output stream.
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,   // out_byte [7:0]
    output logic                             m_tlast
);
    import sfr_pkg::*;

    sfr_entry_t  push_entry;
    sfr_entry_t  head;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;

    sfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    sfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_not_empty (q_not_empty),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire
